### rtl/nmt_pkg.sv
// Shared types, constants and helper functions for the NAT mapping table.
// No dependencies; imported by every module of the block.
package nmt_pkg;

  localparam int TBL_N  = 64;
  localparam int TBL_AW = $clog2(TBL_N);

  localparam logic [15:0] RST_TIMEOUT = 16'd60;
  localparam logic [15:0] RST_MIN_ID  = 16'd1024;
  localparam logic [15:0] RST_MAX_ID  = 16'd65535;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_LOOK_OUTER  = 2'd1,
    OP_LOOK_INNER  = 2'd2,
    OP_INSERT      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_MIN_ID  = 2'd1,
    REG_MAX_ID  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_LOOK,
    S_ALLOC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        proto;
    logic [31:0] addr;
    logic [15:0] iid;
    logic [15:0] oid;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] min_id;
    logic [15:0] max_id;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_run;
    logic retry;
    logic tick_end;
    logic miss;
    logic ins_full;
    logic ins_write;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic scan_hit;
    logic tries_max;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] adv_id(input logic [15:0] v, input cfg_t c);
    adv_id = (v == c.max_id) ? c.min_id : v + 16'd1;
  endfunction

endpackage

### rtl/nat_mapping_table.sv
// NAT mapping table top level: APB register file, sequencer and datapath.
// Depends on nmt_pkg, nmt_ctrl and nmt_dp.
//
// The table holds up to 64 mappings (protocol, inner address, inner id, outer
// id, stamp) in a single-port-write, registered-read ring memory, newest
// first. Every item but an insert into a full table walks the valid entries
// one per cycle through that memory read port: a tick compacts survivors in
// place, a lookup stops at the newest match, and an insert restarts the walk
// for each outer-id candidate found in use (at most 64 candidates). A
// finished result sits in an output register, so the next item is taken as
// soon as the result is loaded there. Registers at byte 0 (query timeout), 4
// (min outer id) and 8 (max outer id) may be written only while the block is
// idle.
module nat_mapping_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic        in_proto,
  input  logic [31:0] in_inner_addr,
  input  logic [15:0] in_inner_id,
  input  logic [15:0] in_outer_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_addr,
  output logic [15:0] out_found_inner_id,
  output logic [15:0] out_found_outer_id,
  output logic        out_found_proto,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nmt_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register file: writes beyond the list drop silently
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout <= RST_TIMEOUT;
      cfg_r.min_id  <= RST_MIN_ID;
      cfg_r.max_id  <= RST_MAX_ID;
    end else if (wr_en) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_TIMEOUT: cfg_r.timeout <= pwdata[15:0];
        REG_MIN_ID:  cfg_r.min_id  <= pwdata[15:0];
        REG_MAX_ID:  cfg_r.max_id  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_TIMEOUT: prdata = {16'd0, cfg_r.timeout};
      REG_MIN_ID:  prdata = {16'd0, cfg_r.min_id};
      REG_MAX_ID:  prdata = {16'd0, cfg_r.max_id};
      default:     prdata = '0;
    endcase
  end

  nmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (op_t'(in_opcode)),
    .sts      (sts),
    .cmd      (cmd)
  );

  nmt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg                (cfg_r),
    .in_opcode          (in_opcode),
    .in_proto           (in_proto),
    .in_inner_addr      (in_inner_addr),
    .in_inner_id        (in_inner_id),
    .in_outer_id        (in_outer_id),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_addr     (out_found_addr),
    .out_found_inner_id (out_found_inner_id),
    .out_found_outer_id (out_found_outer_id),
    .out_found_proto    (out_found_proto)
  );

endmodule

### rtl/nmt_ctrl.sv
// Sequencer for the NAT mapping table: accepts items and steers the datapath.
// Depends on nmt_pkg.
module nmt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nmt_pkg::op_t  in_op,
  input  nmt_pkg::sts_t sts,
  output nmt_pkg::cmd_t cmd
);
  import nmt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept     = 1'b1;
          cmd.scan_start = 1'b1;
          unique case (in_op)
            OP_TICK:                      state_nxt = S_TICK;
            OP_LOOK_OUTER, OP_LOOK_INNER: state_nxt = S_LOOK;
            OP_INSERT:                    state_nxt = S_ALLOC;
            default:                      state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.tick_end = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_LOOK: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.miss  = !sts.scan_hit;
          state_nxt = S_FIN;
        end
      end
      S_ALLOC: begin
        priority if (sts.full) begin
          cmd.ins_full = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.scan_run = 1'b1;
          // candidate in use: move on and rescan, unless out of tries
          priority if (sts.scan_hit && !sts.tries_max) begin
            cmd.retry      = 1'b1;
            cmd.scan_start = 1'b1;
          end else if (sts.scan_done) begin
            cmd.ins_write = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            state_nxt = S_ALLOC;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/nmt_dp.sv
// Datapath of the NAT mapping table: entry ring memory, scan counters,
// id allocator, clock of seconds and the result register. Depends on nmt_pkg.
module nmt_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  nmt_pkg::cmd_t cmd,
  output nmt_pkg::sts_t sts,
  input  nmt_pkg::cfg_t cfg,
  input  logic [1:0]    in_opcode,
  input  logic          in_proto,
  input  logic [31:0]   in_inner_addr,
  input  logic [15:0]   in_inner_id,
  input  logic [15:0]   in_outer_id,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [31:0]   out_found_addr,
  output logic [15:0]   out_found_inner_id,
  output logic [15:0]   out_found_outer_id,
  output logic          out_found_proto
);
  import nmt_pkg::*;

  entry_t mem [TBL_N];
  entry_t rd_data_r;
  logic [TBL_AW-1:0] rd_addr;
  logic              we;
  logic [TBL_AW-1:0] wa;
  entry_t            wd;

  logic [TBL_AW-1:0] head_r, head_nxt;
  logic [TBL_AW:0]   count_r, count_nxt;
  logic [31:0]       now_r, now_nxt;
  logic [15:0]       nq_r, nq_nxt, ns_r, ns_nxt;
  op_t               op_r;
  logic              proto_r;
  logic [31:0]       addr_r;
  logic [15:0]       iid_r, oid_r;
  logic [TBL_AW:0]   idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [TBL_AW-1:0] pidx_r, pidx_nxt;
  logic [TBL_AW:0]   wr_r, wr_nxt;
  logic [15:0]       cand_r, cand_nxt;
  logic [TBL_AW-1:0] tries_r, tries_nxt;
  entry_t            res_r, res_nxt;
  logic [1:0]        rst_r, rst_nxt;
  logic              ov_r, ov_nxt;
  entry_t            out_r;
  logic [1:0]        ost_r;

  logic issue, match, keep, hit;

  assign rd_addr = head_r + idx_r[TBL_AW-1:0];
  assign issue   = cmd.scan_run && (idx_r != count_r);

  always_comb begin
    unique case (op_r)
      OP_LOOK_OUTER: match = (rd_data_r.proto == proto_r) && (rd_data_r.oid == oid_r);
      OP_LOOK_INNER: match = (rd_data_r.proto == proto_r) && (rd_data_r.addr == addr_r)
                             && (rd_data_r.iid == iid_r);
      OP_INSERT:     match = (rd_data_r.proto == proto_r) && (rd_data_r.oid == cand_r);
      default:       match = 1'b0;
    endcase
  end

  assign keep = (op_r == OP_TICK) && !rd_data_r.proto
                && ((now_r - rd_data_r.stamp) <= {16'd0, cfg.timeout});
  assign hit  = cmd.scan_run && pend_r && match;

  assign sts.full      = (count_r == (TBL_AW+1)'(TBL_N));
  assign sts.scan_hit  = hit;
  assign sts.scan_done = hit || (!pend_r && (idx_r == count_r));
  assign sts.tries_max = (tries_r == TBL_AW'(TBL_N - 1));
  assign sts.out_free  = !ov_r || out_ready;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    now_nxt   = now_r;
    nq_nxt    = nq_r;
    ns_nxt    = ns_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    wr_nxt    = wr_r;
    cand_nxt  = cand_r;
    tries_nxt = tries_r;
    res_nxt   = res_r;
    rst_nxt   = rst_r;
    we        = 1'b0;
    wa        = head_r;
    wd        = rd_data_r;
    ov_nxt    = ov_r && !out_ready;

    if (issue) begin
      idx_nxt  = idx_r + 1'b1;
      pend_nxt = 1'b1;
      pidx_nxt = idx_r[TBL_AW-1:0];
    end

    // tick: copy survivors down toward the head, order kept
    if (cmd.scan_run && pend_r && keep) begin
      we     = 1'b1;
      wa     = head_r + wr_r[TBL_AW-1:0];
      wr_nxt = wr_r + 1'b1;
    end

    // lookup hit: refresh the stamp and hold the entry as the result
    if (hit && (op_r != OP_INSERT)) begin
      we       = 1'b1;
      wa       = head_r + pidx_r;
      wd.stamp = now_r;
      res_nxt  = rd_data_r;
      rst_nxt  = ST_OK;
    end

    if (cmd.scan_start) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
      wr_nxt   = '0;
    end

    if (cmd.accept) begin
      cand_nxt  = in_proto ? ns_r : nq_r;
      tries_nxt = '0;
      if (op_t'(in_opcode) == OP_TICK) now_nxt = now_r + 32'd1;
    end

    if (cmd.retry) begin
      cand_nxt  = adv_id(cand_r, cfg);
      tries_nxt = tries_r + 1'b1;
    end

    if (cmd.tick_end) begin
      count_nxt = wr_r;
      res_nxt   = '0;
      rst_nxt   = ST_OK;
    end

    if (cmd.miss) begin
      res_nxt = '0;
      rst_nxt = ST_MISS;
    end

    if (cmd.ins_full) begin
      res_nxt = '0;
      rst_nxt = ST_FULL;
    end

    if (cmd.ins_write) begin
      head_nxt  = head_r - 1'b1;
      count_nxt = count_r + 1'b1;
      we        = 1'b1;
      wa        = head_r - 1'b1;
      wd        = '{proto: proto_r, addr: addr_r, iid: iid_r, oid: cand_r, stamp: now_r};
      res_nxt   = wd;
      rst_nxt   = ST_OK;
      if (proto_r) ns_nxt = adv_id(cand_r, cfg);
      else         nq_nxt = adv_id(cand_r, cfg);
    end

    if (cmd.load_out) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      now_r   <= '0;
      nq_r    <= RST_MIN_ID;
      ns_r    <= RST_MIN_ID;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      now_r   <= now_nxt;
      nq_r    <= nq_nxt;
      ns_r    <= ns_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    wr_r    <= wr_nxt;
    cand_r  <= cand_nxt;
    tries_r <= tries_nxt;
    res_r   <= res_nxt;
    rst_r   <= rst_nxt;
    if (cmd.accept) begin
      op_r    <= op_t'(in_opcode);
      proto_r <= in_proto;
      addr_r  <= in_inner_addr;
      iid_r   <= in_inner_id;
      oid_r   <= in_outer_id;
    end
    if (cmd.load_out) begin
      out_r <= res_r;
      ost_r <= rst_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_found_addr     = out_r.addr;
  assign out_found_inner_id = out_r.iid;
  assign out_found_outer_id = out_r.oid;
  assign out_found_proto    = out_r.proto;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (TBL_AW+1)'(TBL_N)) else $error("entry count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ({1'b0, pidx_r} < count_r)) else $error("scan read past last entry");

  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> ov_r) else $error("result not presented after load");

endmodule

### verif/tb_nat_mapping_table.sv
// Self-checking testbench for nat_mapping_table: directed and random items
// checked against an in-bench table predictor. Depends on nmt_pkg and the RTL.
module tb_nat_mapping_table;
  timeunit 1ns;
  timeprecision 1ps;
  import nmt_pkg::*;

  localparam int DEPTH      = TBL_N;
  localparam int CYCLE_CAP  = 30000000;

  typedef struct {
    status_t     status;
    logic [31:0] addr;
    logic [15:0] iid;
    logic [15:0] oid;
    logic        proto;
  } nat_result_t;

  // Scoreboard: mirrors the mapping table and keeps the results still owed.
  class nat_table_scoreboard;
    bit          vld[DEPTH];
    bit          pr[DEPTH];
    bit [31:0]   ad[DEPTH];
    bit [15:0]   iid[DEPTH];
    bit [15:0]   oid[DEPTH];
    bit [31:0]   stamp[DEPTH];
    bit [31:0]   now_sec;
    bit [15:0]   next_id[2];
    bit [15:0]   timeout, min_id, max_id;
    nat_result_t owed_results[$];
    int          errors;

    function new();
      timeout = RST_TIMEOUT;
      min_id  = RST_MIN_ID;
      max_id  = RST_MAX_ID;
      next_id[0] = RST_MIN_ID;
      next_id[1] = RST_MIN_ID;
    endfunction

    function void set_reg(reg_idx_t idx, bit [15:0] v);
      case (idx)
        REG_TIMEOUT: timeout = v;
        REG_MIN_ID:  min_id = v;
        default:     max_id = v;
      endcase
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < DEPTH; i++) if (vld[i]) n++;
      return n;
    endfunction

    function bit [15:0] next_after(bit [15:0] v);
      return (v == max_id) ? min_id : v + 16'd1;
    endfunction

    function bit id_taken(bit [15:0] id, bit p);
      for (int i = 0; i < DEPTH; i++)
        if (vld[i] && pr[i] == p && oid[i] == id) return 1;
      return 0;
    endfunction

    function void move_slot(int d, int s);
      vld[d] = vld[s]; pr[d] = pr[s]; ad[d] = ad[s];
      iid[d] = iid[s]; oid[d] = oid[s]; stamp[d] = stamp[s];
    endfunction

    function nat_result_t slot_result(status_t st, int s);
      nat_result_t r;
      r.status = st;
      r.addr = (s < 0) ? '0 : ad[s];
      r.iid = (s < 0) ? '0 : iid[s];
      r.oid = (s < 0) ? '0 : oid[s];
      r.proto = (s < 0) ? 1'b0 : pr[s];
      return r;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Advance the table for one accepted item and queue its result.
    function void note_item(op_t op, bit p, bit [31:0] a, bit [15:0] ii, bit [15:0] oi);
      int w;
      bit hit;
      bit [15:0] cand;
      nat_result_t r;
      r = slot_result(ST_MISS, -1);
      case (op)
        OP_TICK: begin
          w = 0;
          now_sec = now_sec + 1;
          for (int i = 0; i < DEPTH; i++) begin
            if (vld[i] && !pr[i] && (now_sec - stamp[i]) <= {16'd0, timeout}) begin
              if (w != i) move_slot(w, i);
              w++;
            end
          end
          for (int i = w; i < DEPTH; i++) vld[i] = 0;
          r = slot_result(ST_OK, -1);
        end
        OP_LOOK_OUTER, OP_LOOK_INNER: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (vld[i] && pr[i] == p) begin
              hit = (op == OP_LOOK_OUTER) ? (oid[i] == oi) : (ad[i] == a && iid[i] == ii);
              if (hit) begin
                stamp[i] = now_sec;
                r = slot_result(ST_OK, i);
                break;
              end
            end
          end
        end
        default: begin
          if (vld[DEPTH-1]) begin
            r = slot_result(ST_FULL, -1);
          end else begin
            cand = next_id[p];
            for (int t = 1; t < DEPTH && id_taken(cand, p); t++) cand = next_after(cand);
            next_id[p] = next_after(cand);
            for (int i = DEPTH - 1; i > 0; i--) move_slot(i, i - 1);
            vld[0] = 1; pr[0] = p; ad[0] = a; iid[0] = ii; oid[0] = cand;
            stamp[0] = now_sec;
            r = slot_result(ST_OK, 0);
          end
        end
      endcase
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] a, logic [15:0] ii,
                               logic [15:0] oi, logic p);
      nat_result_t e;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d", $time, st);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      if (st !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, st); errors++;
      end
      if (a !== e.addr) begin
        $display("%0t: addr exp %h got %h", $time, e.addr, a); errors++;
      end
      if (ii !== e.iid) begin
        $display("%0t: inner id exp %h got %h", $time, e.iid, ii); errors++;
      end
      if (oi !== e.oid) begin
        $display("%0t: outer id exp %h got %h", $time, e.oid, oi); errors++;
      end
      if (p !== e.proto) begin
        $display("%0t: proto exp %0d got %0d", $time, e.proto, p); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_opcode;
  logic        in_proto;
  logic [31:0] in_inner_addr;
  logic [15:0] in_inner_id, in_outer_id;
  logic        out_valid, out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_found_addr;
  logic [15:0] out_found_inner_id, out_found_outer_id;
  logic        out_found_proto;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  nat_table_scoreboard sb = new();
  bit idle_en;
  int cycles = 0;

  nat_mapping_table u_dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Run limit: a hung handshake or a lost result ends the test here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("nat_mapping_table test failed");
      $finish;
    end
  end

  // Check every result that the receiver accepts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_found_addr, out_found_inner_id,
                      out_found_outer_id, out_found_proto);
  end

  // Result side: while idle_en is set, stall a random number of cycles before each result.
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = idle_en ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Present one item, hold it until accepted, then record it.
  task automatic send_item(op_t op, bit p, bit [31:0] a, bit [15:0] ii, bit [15:0] oi);
    int gap;
    gap = idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_proto      <= p;
    in_inner_addr <= a;
    in_inner_id   <= ii;
    in_outer_id   <= oi;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, p, a, ii, oi);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register lands at the end of the access cycle.
  task automatic write_reg(reg_idx_t idx, bit [15:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(bit [15:0] tmo, bit [15:0] lo, bit [15:0] hi);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_MIN_ID, lo);
    write_reg(REG_MAX_ID, hi);
    @(posedge clk);
  endtask

  // Random items: lookups, inserts and ticks by the given shares; most lookups aim at live entries.
  task automatic run_random(int n, int ins_pct, int tick_pct);
    int roll, k, cnt;
    bit p;
    bit [31:0] a;
    bit [15:0] ii, oi;
    for (int j = 0; j < n; j++) begin
      // Hold off once mid-phase until the block has returned everything.
      if (j == n / 2) drain();
      if (j % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      p  = $urandom_range(0, 1);
      a  = $urandom;
      ii = $urandom_range(0, 65535);
      oi = $urandom_range(0, 65535);
      cnt = sb.live_count();
      if (cnt > 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, cnt - 1);
        if (roll >= ins_pct + tick_pct) begin
          p = sb.pr[k]; oi = sb.oid[k];
          a = sb.ad[k]; ii = sb.iid[k];
        end else if ($urandom_range(0, 3) == 0) begin
          // re-insert an existing inner pair
          a = sb.ad[k]; ii = sb.iid[k];
        end
      end
      if (roll < tick_pct)
        send_item(OP_TICK, p, a, ii, oi);
      else if (roll < tick_pct + ins_pct)
        send_item(OP_INSERT, p, a, ii, oi);
      else if (roll[0])
        send_item(OP_LOOK_OUTER, p, a, ii, oi);
      else
        send_item(OP_LOOK_INNER, p, a, ii, oi);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_opcode = OP_TICK; in_proto = 1'b0;
    in_inner_addr = '0; in_inner_id = '0; in_outer_id = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_en = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, both protocols, field extremes, stream aging.
    send_item(OP_TICK, 1'b0, '0, '0, '0);
    send_item(OP_LOOK_OUTER, 1'b0, '0, '0, 16'd1024);
    send_item(OP_LOOK_INNER, 1'b1, '1, '1, '0);
    send_item(OP_INSERT, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
    send_item(OP_INSERT, 1'b1, 32'h0000_0000, 16'h0000, 16'hFFFF);
    send_item(OP_INSERT, 1'b1, 32'hA5A5_5A5A, 16'h1234, 16'h0000);
    send_item(OP_LOOK_OUTER, 1'b0, '0, '0, 16'd1024);
    send_item(OP_LOOK_OUTER, 1'b1, '0, '0, 16'd1024);
    send_item(OP_LOOK_OUTER, 1'b1, '0, '0, 16'd1025);
    send_item(OP_LOOK_INNER, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, '0);
    send_item(OP_LOOK_INNER, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, '0);
    send_item(OP_LOOK_INNER, 1'b1, 32'h0000_0000, 16'h0000, '1);
    send_item(OP_TICK, 1'b1, '1, '1, '1);
    send_item(OP_LOOK_OUTER, 1'b1, '0, '0, 16'd1024);
    send_item(OP_LOOK_INNER, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, '0);
    drain();

    // Zero timeout and a six-id window that wraps at the top of the range.
    configure(16'd0, 16'd65530, 16'd65535);
    run_random(400, 35, 25);

    // Single-id window: allocations collide once the id is in use.
    configure(16'hFFFF, 16'd0, 16'd0);
    run_random(25, 40, 30);

    // Minimum above maximum, short timeout.
    configure(16'd3, 16'd100, 16'd50);
    run_random(400, 30, 15);

    // Wide range and long timeout: fill the table until inserts report full.
    configure(16'hFFFF, 16'd1024, 16'd65535);
    run_random(600, 45, 2);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0)
      $display("nat_mapping_table test passed");
    else
      $display("nat_mapping_table test failed");
    $finish;
  end

endmodule
